// ===== rtl/pds_pkg.sv =====
// Shared constants for the PLL divider solver.
package pds_pkg;

  // VCO lower limit in Hz; also the upper clamp of a request
  localparam logic [31:0] VCO_MIN_HZ  = 32'd2133000000;
  localparam logic [31:0] RATE_MAX_HZ = VCO_MIN_HZ;
  // Lower clamp: VCO minimum over 64
  localparam logic [31:0] RATE_MIN_HZ = VCO_MIN_HZ / 32'd64;

  // Largest post-divider exponent
  localparam logic [2:0] EXP_MAX = 3'd6;

  // Reference frequency after reset
  localparam logic [29:0] REF_RESET = 30'd33333333;

  // Largest feedback code the register field holds
  localparam logic [7:0] CODE_MAX = 8'd255;

endpackage

// ===== rtl/pds_if.sv =====
// Channel interfaces of the PLL divider solver (request, result, config).

interface pds_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] target_rate;

  modport source (output valid, output target_rate, input ready);
  modport sink   (input valid, input target_rate, output ready);
endinterface

interface pds_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  post_div_exp;
  logic [7:0]  feedback_div;
  logic [36:0] achieved_rate;
  logic        div_saturated;

  modport source (output valid, output post_div_exp, output feedback_div,
                  output achieved_rate, output div_saturated, input ready);
  modport sink   (input valid, input post_div_exp, input feedback_div,
                  input achieved_rate, input div_saturated, output ready);
endinterface

interface pds_cfg_if;
  logic        valid;
  logic        ready;
  logic [29:0] reference_freq;

  modport source (output valid, output reference_freq, input ready);
  modport sink   (input valid, input reference_freq, output ready);
endinterface

// ===== rtl/pll_divider_solver_core.sv =====
// PLL divider solver: pipelined top level.
//
// Usage:
//   in_chan   - one requested output frequency (Hz) per transaction.
//   out_chan  - one result per request, in order: post-divider exponent,
//               feedback code, achieved frequency and a saturation flag.
//   cfg_chan  - writes the reference frequency (Hz); always ready. Write it
//               only while no request is in flight.
// A new request is taken every cycle and throughput is one result per
// cycle while the receiver is ready to take results.
// The feedback quotient comes from a restoring divider unrolled across
// three stages of three quotient bits each, after a clamp/exponent stage
// and a numerator stage; a multiply stage and a shift stage follow.
// Reset clears all stage valid bits and loads the reference with
// 33333333 Hz. When the receiver stalls, each stage holds its transaction
// and accepts a new one only once its successor frees up, so bubbles
// are squeezed out and the input keeps flowing until the pipe is full.
module pll_divider_solver_core (
  input  logic                 clk,
  input  logic                 rst_n,
  pds_in_if.sink               in_chan,
  pds_out_if.source            out_chan,
  pds_cfg_if.sink              cfg_chan
);

  typedef struct packed {
    logic [32:0] rem;
    logic [2:0]  q;
  } div_part_t;

  // Three restoring division steps, quotient bits top..top-2
  function automatic div_part_t div3(input logic [32:0] rem_in,
                                     input logic [29:0] d,
                                     input logic [3:0]  top);
    div_part_t   res;
    logic [38:0] r;
    logic [38:0] dk;
    r   = {6'd0, rem_in};
    res = '0;
    for (int i = 0; i < 3; i++) begin
      dk = {9'd0, d} << (top - 4'(i));
      if (r >= dk) begin
        r = r - dk;
        res.q[2 - i] = 1'b1;
      end
    end
    res.rem = r[32:0];
    return res;
  endfunction

  // Configuration: reference and its 257x multiple for the saturation test
  logic [29:0] ref_r;
  logic [38:0] ref257_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r    <= pds_pkg::REF_RESET;
      ref257_r <= {1'b0, pds_pkg::REF_RESET, 8'd0} + {9'd0, pds_pkg::REF_RESET};
    end else if (cfg_chan.valid) begin
      ref_r    <= cfg_chan.reference_freq;
      ref257_r <= {1'b0, cfg_chan.reference_freq, 8'd0} +
                  {9'd0, cfg_chan.reference_freq};
    end
  end

  // Stage valid bits and advance enables
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r, s6_vld_r, s7_vld_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  assign en7 = !s7_vld_r || out_chan.ready;
  assign en6 = !s6_vld_r || en7;
  assign en5 = !s5_vld_r || en6;
  assign en4 = !s4_vld_r || en5;
  assign en3 = !s3_vld_r || en4;
  assign en2 = !s2_vld_r || en3;
  assign en1 = !s1_vld_r || en2;

  assign in_chan.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else begin
      if (en1) s1_vld_r <= in_chan.valid;
      if (en2) s2_vld_r <= s1_vld_r;
      if (en3) s3_vld_r <= s2_vld_r;
      if (en4) s4_vld_r <= s3_vld_r;
      if (en5) s5_vld_r <= s4_vld_r;
      if (en6) s6_vld_r <= s5_vld_r;
      if (en7) s7_vld_r <= s6_vld_r;
    end
  end

  // Stage 1: clamp request, pick smallest exponent reaching VCO minimum
  logic [31:0] s1_rate_nxt, s1_rate_r;
  logic [2:0]  s1_exp_nxt, s1_exp_r;

  always_comb begin
    if (in_chan.target_rate < pds_pkg::RATE_MIN_HZ) begin
      s1_rate_nxt = pds_pkg::RATE_MIN_HZ;
    end else if (in_chan.target_rate > pds_pkg::RATE_MAX_HZ) begin
      s1_rate_nxt = pds_pkg::RATE_MAX_HZ;
    end else begin
      s1_rate_nxt = in_chan.target_rate;
    end
    s1_exp_nxt = pds_pkg::EXP_MAX;
    for (int k = 6; k >= 1; k--) begin
      if (({6'd0, s1_rate_nxt} << k) >= {6'd0, pds_pkg::VCO_MIN_HZ}) begin
        s1_exp_nxt = 3'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_rate_r <= s1_rate_nxt;
      s1_exp_r  <= s1_exp_nxt;
    end
  end

  // Stage 2: VCO frequency plus half the reference
  logic [32:0] s2_num_nxt, s2_num_r;
  logic [2:0]  s2_exp_r;

  assign s2_num_nxt = 33'({6'd0, s1_rate_r} << s1_exp_r) + 33'(ref_r >> 1);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_num_r <= s2_num_nxt;
      s2_exp_r <= s1_exp_r;
    end
  end

  // Stage 3: saturation test and quotient bits 8..6
  div_part_t   s3_div_nxt;
  logic        s3_sat_nxt;
  logic [32:0] s3_rem_r;
  logic [8:0]  s3_q_r;
  logic        s3_sat_r;
  logic [2:0]  s3_exp_r;

  assign s3_div_nxt = div3(s2_num_r, ref_r, 4'd8);
  assign s3_sat_nxt = {6'd0, s2_num_r} >= ref257_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_rem_r <= s3_div_nxt.rem;
      s3_q_r   <= {s3_div_nxt.q, 6'd0};
      s3_sat_r <= s3_sat_nxt;
      s3_exp_r <= s2_exp_r;
    end
  end

  // Stage 4: quotient bits 5..3
  div_part_t   s4_div_nxt;
  logic [32:0] s4_rem_r;
  logic [8:0]  s4_q_r;
  logic        s4_sat_r;
  logic [2:0]  s4_exp_r;

  assign s4_div_nxt = div3(s3_rem_r, ref_r, 4'd5);

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_rem_r <= s4_div_nxt.rem;
      s4_q_r   <= {s3_q_r[8:6], s4_div_nxt.q, 3'd0};
      s4_sat_r <= s3_sat_r;
      s4_exp_r <= s3_exp_r;
    end
  end

  // Stage 5: quotient bits 2..0, then feedback code
  div_part_t  s5_div_nxt;
  logic [8:0] s5_quot;
  logic [7:0] s5_code_nxt, s5_code_r;
  logic       s5_sat_r;
  logic [2:0] s5_exp_r;

  assign s5_div_nxt = div3(s4_rem_r, ref_r, 4'd2);
  assign s5_quot    = {s4_q_r[8:3], s5_div_nxt.q};

  always_comb begin
    if (s4_sat_r) begin
      s5_code_nxt = pds_pkg::CODE_MAX;
    end else if (s5_quot == 9'd0) begin
      s5_code_nxt = 8'd0;
    end else begin
      s5_code_nxt = 8'(s5_quot - 9'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_code_r <= s5_code_nxt;
      s5_sat_r  <= s4_sat_r;
      s5_exp_r  <= s4_exp_r;
    end
  end

  // Stage 6: VCO actually produced, reference times (code + 1)
  logic [38:0] s6_prod_nxt, s6_prod_r;
  logic [7:0]  s6_code_r;
  logic        s6_sat_r;
  logic [2:0]  s6_exp_r;

  assign s6_prod_nxt = {9'd0, ref_r} * {30'd0, {1'b0, s5_code_r} + 9'd1};

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_prod_r <= s6_prod_nxt;
      s6_code_r <= s5_code_r;
      s6_sat_r  <= s5_sat_r;
      s6_exp_r  <= s5_exp_r;
    end
  end

  // Stage 7: post-divider shift into the output register
  logic [36:0] s7_rate_nxt, s7_rate_r;
  logic [7:0]  s7_code_r;
  logic        s7_sat_r;
  logic [2:0]  s7_exp_r;

  assign s7_rate_nxt = 37'(s6_prod_r >> s6_exp_r);

  always_ff @(posedge clk) begin
    if (en7) begin
      s7_rate_r <= s7_rate_nxt;
      s7_code_r <= s6_code_r;
      s7_sat_r  <= s6_sat_r;
      s7_exp_r  <= s6_exp_r;
    end
  end

  assign out_chan.valid         = s7_vld_r;
  assign out_chan.post_div_exp  = s7_exp_r;
  assign out_chan.feedback_div  = s7_code_r;
  assign out_chan.achieved_rate = s7_rate_r;
  assign out_chan.div_saturated = s7_sat_r;

endmodule
